>>> src/assert_macros.svh
// Assertion helpers for the RTL files; eipx_parse includes them.
// Both macros sample on the rising edge of clock and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never occurs.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

>>> src/eipx_pkg.sv
// ----------------------------------------------------------------------------
// eipx_pkg
// Types and constants of the Ethernet/IP header extractor.
// ----------------------------------------------------------------------------
package eipx_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } eipx_req_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  tag;
      logic [63:0] value;
      logic        last_word;
   } eipx_rsp_type;

   // Read port of the header store.
   typedef struct packed {
      logic       en;
      logic [6:0] addr;
   } eipx_rd_type;

   // End-of-frame notice from the capture side.
   typedef struct packed {
      logic        done;
      logic [15:0] len;
   } eipx_frame_type;

   // Word handed to the output register.
   typedef struct packed {
      logic         valid;
      eipx_rsp_type word;
   } eipx_push_type;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [3:0] TAG_MAC_DST  = 4'd0;
   localparam logic [3:0] TAG_MAC_SRC  = 4'd1;
   localparam logic [3:0] TAG_ETYPE    = 4'd2;
   localparam logic [3:0] TAG_IPV6     = 4'd3;
   localparam logic [3:0] TAG_PROTO    = 4'd4;
   localparam logic [3:0] TAG_SRC_HI   = 4'd5;
   localparam logic [3:0] TAG_SRC_LO   = 4'd6;
   localparam logic [3:0] TAG_DST_HI   = 4'd7;
   localparam logic [3:0] TAG_DST_LO   = 4'd8;
   localparam logic [3:0] TAG_L4       = 4'd9;
   localparam logic [3:0] TAG_SPORT    = 4'd10;
   localparam logic [3:0] TAG_DPORT    = 4'd11;
   localparam logic [3:0] TAG_TCP_FLAG = 4'd12;
   localparam logic [3:0] TAG_PAY_OFF  = 4'd13;
   localparam logic [3:0] TAG_PAY_LEN  = 4'd14;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   localparam logic [7:0]  ETH_HDR_LEN  = 8'd14;
   localparam logic [15:0] IPV4_MIN_LEN = 16'd34;
   localparam logic [15:0] IPV6_MIN_LEN = 16'd54;
   localparam logic [7:0]  IPV6_PAY_OFF = 8'd54;
   localparam logic [7:0]  TCP_HDR_LEN  = 8'd20;
   localparam logic [7:0]  UDP_HDR_LEN  = 8'd8;
   localparam logic [7:0]  ICMP_HDR_LEN = 8'd4;

endpackage

>>> src/eipx_store.sv
// ----------------------------------------------------------------------------
// eipx_store
// Header byte memory and saturating frame byte counter.
// ----------------------------------------------------------------------------
module eipx_store #(
   parameter int HEADER_BYTES    = 128,
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  eipx_pkg::eipx_req_type   req_word,
   input  eipx_pkg::eipx_rd_type    rd,
   output logic [7:0]               rd_data,
   output eipx_pkg::eipx_frame_type frame
);
   import eipx_pkg::*;

   localparam int AW = $clog2(HEADER_BYTES);

   logic [7:0]  mem [HEADER_BYTES];
   logic [7:0]  rd_data_ff;
   logic [15:0] cnt_ff;
   logic [15:0] cnt_in;
   logic [15:0] cnt_inc;
   logic        wr_en;

   assign wr_en   = accept && (cnt_ff < 16'(HEADER_BYTES));
   assign cnt_inc = (cnt_ff < 16'(MAX_FRAME_BYTES)) ? cnt_ff + 16'd1 : cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = req_word.frame_end ? 16'd0 : cnt_inc;
      end
   end

   assign frame.done = accept && req_word.frame_end;
   assign frame.len  = cnt_inc;
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[AW-1:0]] <= req_word.data_byte;
      end
      if (rd.en) begin
         rd_data_ff <= mem[AW'(rd.addr)];
      end
   end

endmodule

>>> src/eipx_parse.sv
// ----------------------------------------------------------------------------
// eipx_parse
// Parse sequencer: walks the descriptor steps, fetches header bytes one per
// cycle from the store and hands finished words to the output register.
// ----------------------------------------------------------------------------
module eipx_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  eipx_pkg::eipx_frame_type frame,
   output eipx_pkg::eipx_rd_type    rd,
   input  logic [7:0]               rd_data,
   input  logic                     push_ready,
   output eipx_pkg::eipx_push_type  push,
   output logic                     busy
);
   import eipx_pkg::*;
   `include "assert_macros.svh"

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_FETCH = 2'd1;
   localparam logic [1:0] PH_EMIT  = 2'd2;

   localparam logic [4:0] ST_ET      = 5'd0;
   localparam logic [4:0] ST_MAC_DST = 5'd1;
   localparam logic [4:0] ST_MAC_SRC = 5'd2;
   localparam logic [4:0] ST_ETYPE   = 5'd3;
   localparam logic [4:0] ST_V6      = 5'd4;
   localparam logic [4:0] ST_PROTO   = 5'd5;
   localparam logic [4:0] ST_SRC_HI  = 5'd6;
   localparam logic [4:0] ST_SRC_LO  = 5'd7;
   localparam logic [4:0] ST_DST_HI  = 5'd8;
   localparam logic [4:0] ST_DST_LO  = 5'd9;
   localparam logic [4:0] ST_IHL     = 5'd10;
   localparam logic [4:0] ST_L4      = 5'd11;
   localparam logic [4:0] ST_SPORT   = 5'd12;
   localparam logic [4:0] ST_DPORT   = 5'd13;
   localparam logic [4:0] ST_FLAGS   = 5'd14;
   localparam logic [4:0] ST_DOFF    = 5'd15;
   localparam logic [4:0] ST_POFF    = 5'd16;
   localparam logic [4:0] ST_PLEN    = 5'd17;
   localparam logic [4:0] ST_REJECT  = 5'd18;

   localparam logic [1:0] L4_NONE = 2'd0;
   localparam logic [1:0] L4_TCP  = 2'd1;
   localparam logic [1:0] L4_UDP  = 2'd2;
   localparam logic [1:0] L4_ICMP = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  step_ff, step_in;
   logic        rdv_ff, rdv_in;
   logic [6:0]  addr_ff, addr_in;
   logic [3:0]  rem_ff, rem_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  off_ff, off_in;
   logic [15:0] et_ff, et_in;
   logic        v6_ff, v6_in;
   logic [7:0]  proto_ff, proto_in;
   logic [1:0]  l4_ff, l4_in;

   logic [4:0]  step_nxt;
   logic        adv;
   logic        fin;
   logic [6:0]  f_addr;
   logic [3:0]  f_cnt;
   logic [7:0]  ihl_off;
   logic [15:0] ihl_off_w;
   logic [15:0] off_w;
   logic [15:0] et_new;
   logic        ok4;
   logic        ok6;

   assign ihl_off   = ETH_HDR_LEN + {2'b00, acc_ff[3:0], 2'b00};
   assign ihl_off_w = {8'h00, ihl_off};
   assign off_w     = {8'h00, off_ff};
   assign et_new    = acc_ff[15:0];
   assign ok4       = (et_new == ETYPE_IPV4) && (len_ff >= IPV4_MIN_LEN);
   assign ok6       = (et_new == ETYPE_IPV6) && (len_ff >= IPV6_MIN_LEN);

   // step control and word build
   always_comb begin
      step_nxt   = step_ff;
      adv        = 1'b0;
      fin        = 1'b0;
      len_in     = len_ff;
      off_in     = off_ff;
      et_in      = et_ff;
      v6_in      = v6_ff;
      proto_in   = proto_ff;
      l4_in      = l4_ff;
      push       = '0;
      push.word.status = STATUS_OK;
      unique case (phase_ff)
         PH_IDLE: begin
            if (frame.done) begin
               len_in   = frame.len;
               step_nxt = ST_ET;
               adv      = 1'b1;
            end
         end
         PH_EMIT: begin
            unique case (step_ff)
               ST_ET: begin
                  adv   = 1'b1;
                  et_in = et_new;
                  v6_in = ok6;
                  step_nxt = (ok4 || ok6) ? ST_MAC_DST : ST_REJECT;
               end
               ST_REJECT: begin
                  push.valid          = push_ready;
                  push.word.status    = STATUS_REJECT;
                  push.word.tag       = TAG_MAC_DST;
                  push.word.last_word = 1'b1;
                  adv = push_ready;
                  fin = 1'b1;
               end
               ST_MAC_DST, ST_MAC_SRC, ST_SRC_HI, ST_SRC_LO, ST_DST_HI: begin
                  push.valid      = push_ready;
                  push.word.value = acc_ff;
                  unique case (step_ff)
                     ST_MAC_DST: push.word.tag = TAG_MAC_DST;
                     ST_MAC_SRC: push.word.tag = TAG_MAC_SRC;
                     ST_SRC_HI:  push.word.tag = TAG_SRC_HI;
                     ST_SRC_LO:  push.word.tag = TAG_SRC_LO;
                     default:    push.word.tag = TAG_DST_HI;
                  endcase
                  adv      = push_ready;
                  step_nxt = step_ff + 5'd1;
               end
               ST_ETYPE: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_ETYPE;
                  push.word.value = 64'(et_ff);
                  adv      = push_ready;
                  step_nxt = ST_V6;
               end
               ST_V6: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_IPV6;
                  push.word.value = 64'(v6_ff);
                  adv      = push_ready;
                  step_nxt = ST_PROTO;
               end
               ST_PROTO: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_PROTO;
                  push.word.value = acc_ff;
                  adv      = push_ready;
                  proto_in = acc_ff[7:0];
                  step_nxt = ST_SRC_HI;
               end
               ST_DST_LO: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_DST_LO;
                  push.word.value = acc_ff;
                  adv = push_ready;
                  if (v6_ff) begin
                     off_in   = IPV6_PAY_OFF;
                     step_nxt = ST_POFF;
                  end else begin
                     step_nxt = ST_IHL;
                  end
               end
               ST_IHL: begin
                  adv    = 1'b1;
                  off_in = ihl_off;
                  priority if (proto_ff == PROTO_TCP &&
                               len_ff >= ihl_off_w + 16'(TCP_HDR_LEN)) begin
                     l4_in = L4_TCP;
                  end else if (proto_ff == PROTO_UDP &&
                               len_ff >= ihl_off_w + 16'(UDP_HDR_LEN)) begin
                     l4_in = L4_UDP;
                  end else if (proto_ff == PROTO_ICMP &&
                               len_ff >= ihl_off_w + 16'(ICMP_HDR_LEN)) begin
                     l4_in = L4_ICMP;
                  end else begin
                     l4_in = L4_NONE;
                  end
                  step_nxt = (l4_in == L4_NONE) ? ST_POFF : ST_L4;
               end
               ST_L4: begin
                  push.valid    = push_ready;
                  push.word.tag = TAG_L4;
                  unique case (l4_ff)
                     L4_TCP:  push.word.value = 64'(PROTO_TCP);
                     L4_UDP:  push.word.value = 64'(PROTO_UDP);
                     default: push.word.value = 64'(PROTO_ICMP);
                  endcase
                  adv = push_ready;
                  if (l4_ff == L4_ICMP) begin
                     off_in   = off_ff + ICMP_HDR_LEN;
                     step_nxt = ST_POFF;
                  end else begin
                     step_nxt = ST_SPORT;
                  end
               end
               ST_SPORT: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_SPORT;
                  push.word.value = acc_ff;
                  adv      = push_ready;
                  step_nxt = ST_DPORT;
               end
               ST_DPORT: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_DPORT;
                  push.word.value = acc_ff;
                  adv = push_ready;
                  if (l4_ff == L4_TCP) begin
                     step_nxt = ST_FLAGS;
                  end else begin
                     off_in   = off_ff + UDP_HDR_LEN;
                     step_nxt = ST_POFF;
                  end
               end
               ST_FLAGS: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_TCP_FLAG;
                  push.word.value = acc_ff;
                  adv      = push_ready;
                  step_nxt = ST_DOFF;
               end
               ST_DOFF: begin
                  // TCP data offset counts 32-bit words
                  adv      = 1'b1;
                  off_in   = off_ff + {2'b00, acc_ff[7:4], 2'b00};
                  step_nxt = ST_POFF;
               end
               ST_POFF: begin
                  push.valid      = push_ready;
                  push.word.tag   = TAG_PAY_OFF;
                  push.word.value = 64'(off_ff);
                  adv      = push_ready;
                  step_nxt = ST_PLEN;
               end
               ST_PLEN: begin
                  push.valid          = push_ready;
                  push.word.tag       = TAG_PAY_LEN;
                  push.word.value     = (len_ff > off_w) ? 64'(len_ff - off_w) : 64'd0;
                  push.word.last_word = 1'b1;
                  adv = push_ready;
                  fin = 1'b1;
               end
               default: begin
                  adv = 1'b1;
                  fin = 1'b1;
               end
            endcase
         end
         default: ;
      endcase
   end

   // byte fetch for the step being entered
   always_comb begin
      f_addr = '0;
      f_cnt  = '0;
      unique case (step_nxt)
         ST_ET:      begin f_addr = 7'd12; f_cnt = 4'd2; end
         ST_MAC_DST: begin f_addr = 7'd0;  f_cnt = 4'd6; end
         ST_MAC_SRC: begin f_addr = 7'd6;  f_cnt = 4'd6; end
         ST_PROTO:   begin f_addr = v6_ff ? 7'd20 : 7'd23; f_cnt = 4'd1; end
         ST_SRC_HI: begin
            f_addr = 7'd22;
            f_cnt  = v6_ff ? 4'd8 : 4'd0;
         end
         ST_SRC_LO:  begin f_addr = v6_ff ? 7'd30 : 7'd26; f_cnt = v6_ff ? 4'd8 : 4'd4; end
         ST_DST_HI: begin
            f_addr = 7'd38;
            f_cnt  = v6_ff ? 4'd8 : 4'd0;
         end
         ST_DST_LO:  begin f_addr = v6_ff ? 7'd46 : 7'd30; f_cnt = v6_ff ? 4'd8 : 4'd4; end
         ST_IHL:     begin f_addr = 7'd14; f_cnt = 4'd1; end
         ST_SPORT:   begin f_addr = off_ff[6:0]; f_cnt = 4'd2; end
         ST_DPORT:   begin f_addr = 7'(off_ff + 8'd2);  f_cnt = 4'd2; end
         ST_FLAGS:   begin f_addr = 7'(off_ff + 8'd13); f_cnt = 4'd1; end
         ST_DOFF:    begin f_addr = 7'(off_ff + 8'd12); f_cnt = 4'd1; end
         default: ;
      endcase
   end

   assign rd.en   = (phase_ff == PH_FETCH) && (rem_ff != 4'd0);
   assign rd.addr = addr_ff;
   assign busy    = (phase_ff != PH_IDLE);

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      rdv_in   = rd.en;
      if (rdv_ff) begin
         acc_in = {acc_ff[55:0], rd_data};
      end
      if (rd.en) begin
         addr_in = addr_ff + 7'd1;
         rem_in  = rem_ff - 4'd1;
      end
      if (phase_ff == PH_FETCH && rem_ff == 4'd0 && !rdv_ff) begin
         phase_in = PH_EMIT;
      end
      if (adv) begin
         step_in = step_nxt;
         addr_in = f_addr;
         rem_in  = f_cnt;
         acc_in  = '0;
         if (fin) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = (f_cnt == 4'd0) ? PH_EMIT : PH_FETCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= ST_ET;
         rdv_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         rdv_ff   <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
      len_ff   <= len_in;
      off_ff   <= off_in;
      et_ff    <= et_in;
      v6_ff    <= v6_in;
      proto_ff <= proto_in;
      l4_ff    <= l4_in;
   end

   `ASSERT_NEVER(a_push_idle, push.valid && phase_ff == PH_IDLE, "word pushed while idle")
   `ASSERT_CLK(a_rdv_fetch, rdv_ff |-> $past(phase_ff) == PH_FETCH, "read data outside fetch")
   `ASSERT_CLK(a_last_idle, push.valid && push.word.last_word |=> phase_ff == PH_IDLE, "not idle after last word")
   `ASSERT_NEVER(a_off_range, phase_ff == PH_EMIT && step_ff == ST_PLEN && off_ff > 8'd134, "payload offset out of range")

endmodule

>>> src/eipx_out.sv
// ----------------------------------------------------------------------------
// eipx_out
// Output register between the parse sequencer and the result channel.
// ----------------------------------------------------------------------------
module eipx_out (
   input  logic                    clock,
   input  logic                    reset,
   input  eipx_pkg::eipx_push_type push,
   output logic                    push_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output eipx_pkg::eipx_rsp_type  rsp_data
);
   import eipx_pkg::*;

   logic         valid_ff, valid_in;
   eipx_rsp_type data_ff, data_in;

   assign push_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (push.valid) begin
         valid_in = 1'b1;
         data_in  = push.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> src/ethernet_ip_header_extractor.sv
// ----------------------------------------------------------------------------
// ethernet_ip_header_extractor
// Byte-serial Ethernet/IPv4/IPv6/TCP/UDP header parser.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle with no gaps needed; the first
// HEADER_BYTES bytes go into a header memory and the length is counted up to
// MAX_FRAME_BYTES. After the byte marked frame_end the input stalls while the
// parser reads the header back, one byte per cycle through the memory's
// single read port, and emits descriptor words in tag order (or one rejection
// word). The stall also stretches while the result side holds back words; the
// next frame's first byte is accepted as soon as the last word is in the
// output register.
module ethernet_ip_header_extractor #(
   parameter int HEADER_BYTES    = 128,
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  eipx_pkg::eipx_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output eipx_pkg::eipx_rsp_type rsp_data
);
   import eipx_pkg::*;

   logic           accept;
   logic           busy;
   logic           push_ready;
   logic [7:0]     rd_data;
   eipx_rd_type    rd;
   eipx_frame_type frame;
   eipx_push_type  push;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   eipx_store #(
      .HEADER_BYTES    (HEADER_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_data),
      .rd       (rd),
      .rd_data  (rd_data),
      .frame    (frame)
   );

   eipx_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .rd         (rd),
      .rd_data    (rd_data),
      .push_ready (push_ready),
      .push       (push),
      .busy       (busy)
   );

   eipx_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
